>>> hdl/iklp_pkg.sv
package iklp_pkg;

  localparam int MAX_DEPTH_DEF = 8;
  localparam int MAX_TEXT_DEF  = 64;

  // result field widths
  localparam int EV_W    = 4;
  localparam int LEN_W   = 7;
  localparam int DEPTH_W = 5;

  // line phases
  localparam logic [3:0] PH_INDENT = 4'd0;
  localparam logic [3:0] PH_DASH   = 4'd1;
  localparam logic [3:0] PH_KEY    = 4'd2;
  localparam logic [3:0] PH_KEYSP  = 4'd3;
  localparam logic [3:0] PH_SEP    = 4'd4;
  localparam logic [3:0] PH_VAL    = 4'd5;
  localparam logic [3:0] PH_QUOTE  = 4'd6;
  localparam logic [3:0] PH_ESC1   = 4'd7;
  localparam logic [3:0] PH_ESC2   = 4'd8;
  localparam logic [3:0] PH_ESC3   = 4'd9;
  localparam logic [3:0] PH_EOL    = 4'd10;

  // event codes
  localparam logic [EV_W-1:0] EV_KEYCHAR  = 4'd0;
  localparam logic [EV_W-1:0] EV_KEYDONE  = 4'd1;
  localparam logic [EV_W-1:0] EV_VALCHAR  = 4'd2;
  localparam logic [EV_W-1:0] EV_VALDONE  = 4'd3;
  localparam logic [EV_W-1:0] EV_CHILD    = 4'd4;
  localparam logic [EV_W-1:0] EV_PARENT   = 4'd5;
  localparam logic [EV_W-1:0] EV_NEXT     = 4'd6;
  localparam logic [EV_W-1:0] EV_STOP     = 4'd7;
  localparam logic [EV_W-1:0] EV_OVERFLOW = 4'd8;

  // characters
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // datapath commands
  localparam logic [3:0] CMD_NONE    = 4'd0;
  localparam logic [3:0] CMD_RESTART = 4'd1;
  localparam logic [3:0] CMD_LATCH   = 4'd2;
  localparam logic [3:0] CMD_SIMPLE  = 4'd3;
  localparam logic [3:0] CMD_STOP    = 4'd4;
  localparam logic [3:0] CMD_PARENT  = 4'd5;
  localparam logic [3:0] CMD_CHILD   = 4'd6;
  localparam logic [3:0] CMD_NEXT    = 4'd7;
  localparam logic [3:0] CMD_APPEND  = 4'd8;
  localparam logic [3:0] CMD_KEYDONE = 4'd9;

  // byte classes
  localparam logic [1:0] KIND_SIMPLE = 2'd0;
  localparam logic [1:0] KIND_FIRST  = 2'd1;
  localparam logic [1:0] KIND_KEY    = 2'd2;

  typedef struct packed {
    logic [3:0] op;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       simple_emits;
    logic       ind_lt;
    logic       ind_gt;
    logic       level_zero;
    logic       level_max;
    logic       dash;
    logic       text_full;
    logic       eol_char;
    logic       colon;
    logic       halted;
    logic       restart;
    logic       out_free;
  } sta_t;

  // bit 4 flags a valid hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= CH_0 && c <= CH_9) begin
      r = {1'b1, 4'(c - CH_0)};
    end else if (c >= CH_A && c <= CH_F) begin
      r = {1'b1, 4'(c - CH_A + 8'd10)};
    end
    return r;
  endfunction

endpackage

>>> hdl/iklp_if.sv
interface iklp_in_if import iklp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface iklp_out_if import iklp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [EV_W-1:0]    event_res;
  logic [7:0]         char_out;
  logic [LEN_W-1:0]   str_length;
  logic [DEPTH_W-1:0] depth_now;
  logic               last;

  modport source (output valid, output event_res, output char_out, output str_length,
                  output depth_now, output last, input ready);
  modport sink (input valid, input event_res, input char_out, input str_length,
                input depth_now, input last, output ready);
endinterface

>>> hdl/iklp_ctrl.sv
module iklp_ctrl import iklp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sta_t sta,
  output cmd_t cmd
);

  localparam logic [2:0] ST_IDLE         = 3'd0;
  localparam logic [2:0] ST_DISPATCH     = 3'd1;
  localparam logic [2:0] ST_LEVEL        = 3'd2;
  localparam logic [2:0] ST_POP          = 3'd3;
  localparam logic [2:0] ST_APPEND_FIRST = 3'd4;
  localparam logic [2:0] ST_APPEND_KEY   = 3'd5;
  localparam logic [2:0] ST_KEYDONE      = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       key_more;

  // a key char that is cr or lf is followed by key done, unless the text is full
  assign key_more = !sta.text_full && sta.eol_char;

  always_comb begin
    state_next = state;
    cmd.op     = CMD_NONE;
    cmd.last   = 1'b0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (sta.restart) begin
            cmd.op = CMD_RESTART;
          end else if (!sta.halted) begin
            cmd.op     = CMD_LATCH;
            state_next = ST_DISPATCH;
          end
        end
      end
      ST_DISPATCH: begin
        case (sta.kind)
          KIND_SIMPLE: begin
            if (!sta.simple_emits || sta.out_free) begin
              cmd.op     = CMD_SIMPLE;
              cmd.last   = 1'b1;
              state_next = ST_IDLE;
            end
          end
          KIND_FIRST: state_next = ST_LEVEL;
          KIND_KEY: state_next = sta.colon ? ST_KEYDONE : ST_APPEND_KEY;
          default: state_next = ST_IDLE;
        endcase
      end
      ST_LEVEL, ST_POP: begin
        if (sta.ind_lt) begin
          if (sta.out_free) begin
            if (sta.level_zero) begin
              cmd.op     = CMD_STOP;
              cmd.last   = 1'b1;
              state_next = ST_IDLE;
            end else begin
              cmd.op     = CMD_PARENT;
              state_next = ST_POP;
            end
          end
        end else if (sta.ind_gt && state == ST_LEVEL) begin
          if (sta.out_free) begin
            if (sta.level_max) begin
              cmd.op     = CMD_STOP;
              cmd.last   = 1'b1;
              state_next = ST_IDLE;
            end else begin
              cmd.op     = CMD_CHILD;
              state_next = ST_APPEND_FIRST;
            end
          end
        end else if (sta.dash) begin
          if (sta.out_free) begin
            cmd.op     = CMD_NEXT;
            state_next = ST_APPEND_FIRST;
          end
        end else begin
          state_next = ST_APPEND_FIRST;
        end
      end
      ST_APPEND_FIRST: begin
        if (sta.out_free) begin
          cmd.op     = CMD_APPEND;
          cmd.last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_APPEND_KEY: begin
        if (sta.out_free) begin
          cmd.op     = CMD_APPEND;
          cmd.last   = !key_more;
          state_next = key_more ? ST_KEYDONE : ST_IDLE;
        end
      end
      ST_KEYDONE: begin
        if (sta.out_free) begin
          cmd.op     = CMD_KEYDONE;
          cmd.last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hdl/iklp_dpath.sv
module iklp_dpath import iklp_pkg::*; #(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF,
  parameter int MAX_TEXT  = MAX_TEXT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       action,
  input  logic [7:0] data_byte,
  input  cmd_t       cmd,
  output sta_t       sta,
  iklp_out_if.source tx
);

  localparam int LEVEL_W = $clog2(MAX_DEPTH + 1);
  localparam int TEXT_W  = $clog2(MAX_TEXT + 1);
  localparam int STACK_N = MAX_DEPTH + 1;

  logic [3:0]         phase;
  logic [7:0]         line_indent;
  logic [LEVEL_W-1:0] level;
  logic [7:0]         indent_stack [STACK_N];
  logic [TEXT_W-1:0]  tl;
  logic [3:0]         hn;
  logic               halted;
  logic [7:0]         c;

  logic               out_valid;
  logic [EV_W-1:0]    out_ev;
  logic [7:0]         out_ch;
  logic [LEN_W-1:0]   out_len;
  logic [DEPTH_W-1:0] out_dep;
  logic               out_last;

  logic [7:0]         stored;
  logic [7:0]         li_grow;
  logic               is_crlf;
  logic               is_lf;
  logic [4:0]         hex;
  logic               text_full;
  logic               out_free;

  // single-step outcome
  logic [3:0]         s_phase;
  logic [7:0]         s_li;
  logic [TEXT_W-1:0]  s_tl;
  logic [3:0]         s_hn;
  logic               s_halt;
  logic               s_eol;
  logic               s_emit;
  logic [EV_W-1:0]    s_ev;
  logic [7:0]         s_ch;
  logic [LEN_W-1:0]   s_len;
  logic               s_app;
  logic [TEXT_W-1:0]  s_base;
  logic [7:0]         s_ach;

  // emitted beat
  logic               e_valid;
  logic [EV_W-1:0]    e_ev;
  logic [7:0]         e_ch;
  logic [LEN_W-1:0]   e_len;
  logic [LEVEL_W-1:0] lvl_next;
  logic               do_endline;
  logic [1:0]         kind;

  assign stored    = indent_stack[level];
  assign li_grow   = (line_indent == 8'hFF) ? line_indent : line_indent + 8'd1;
  assign is_lf     = (c == CH_LF);
  assign is_crlf   = is_lf || (c == CH_CR);
  assign hex       = hex_value(c);
  assign text_full = (tl >= TEXT_W'(MAX_TEXT));
  assign out_free  = !out_valid || tx.ready;

  always_comb begin
    kind = KIND_SIMPLE;
    if ((phase == PH_INDENT && c != CH_DASH && c != CH_SPACE) ||
        (phase == PH_DASH && c != CH_SPACE)) begin
      kind = KIND_FIRST;
    end else if (phase == PH_KEY && c != CH_SPACE) begin
      kind = KIND_KEY;
    end
  end

  always_comb begin
    s_phase = phase;
    s_li    = line_indent;
    s_tl    = tl;
    s_hn    = hn;
    s_halt  = 1'b0;
    s_eol   = 1'b0;
    s_emit  = 1'b0;
    s_ev    = EV_STOP;
    s_ch    = '0;
    s_len   = '0;
    s_app   = 1'b0;
    s_base  = tl;
    s_ach   = c;
    case (phase)
      PH_INDENT: begin
        if (c == CH_DASH) begin
          s_phase = PH_DASH;
          s_li    = li_grow;
        end else if (c == CH_SPACE) begin
          s_li = li_grow;
        end
      end
      PH_DASH: begin
        if (c == CH_SPACE) begin
          s_li = li_grow;
        end
      end
      PH_KEY: begin
        if (c == CH_SPACE) begin
          s_emit  = 1'b1;
          s_ev    = EV_KEYDONE;
          s_len   = LEN_W'(tl);
          s_phase = PH_KEYSP;
        end
      end
      PH_KEYSP: begin
        if (is_crlf) begin
          s_phase = PH_EOL;
          s_eol   = is_lf;
        end else if (c == CH_COLON) begin
          s_phase = PH_SEP;
        end
      end
      PH_SEP: begin
        if (c == CH_SPACE) begin
          s_phase = phase;
        end else if (is_crlf) begin
          s_phase = PH_EOL;
          s_eol   = is_lf;
        end else if (c == CH_QUOTE) begin
          s_phase = PH_QUOTE;
          s_tl    = '0;
        end else begin
          s_phase = PH_VAL;
          s_app   = 1'b1;
          s_base  = '0;
        end
      end
      PH_QUOTE: begin
        if (c == CH_QUOTE) begin
          s_phase = PH_VAL;
        end else if (c == CH_BSLASH) begin
          s_phase = PH_ESC1;
        end else begin
          s_app = 1'b1;
        end
      end
      PH_ESC1: begin
        if (c == CH_X) begin
          s_phase = PH_ESC2;
        end else begin
          s_emit = 1'b1;
          s_halt = 1'b1;
        end
      end
      PH_ESC2: begin
        if (text_full) begin
          s_emit = 1'b1;
          s_halt = 1'b1;
          s_ev   = EV_OVERFLOW;
        end else if (!hex[4]) begin
          s_emit = 1'b1;
          s_halt = 1'b1;
        end else begin
          s_hn    = hex[3:0];
          s_phase = PH_ESC3;
        end
      end
      PH_ESC3: begin
        if (!hex[4]) begin
          s_emit = 1'b1;
          s_halt = 1'b1;
        end else begin
          s_phase = PH_QUOTE;
          s_app   = 1'b1;
          s_ach   = {hn, hex[3:0]};
        end
      end
      PH_VAL: begin
        if (c == CH_SPACE || is_crlf) begin
          s_emit  = 1'b1;
          s_ev    = EV_VALDONE;
          s_len   = LEN_W'(tl);
          s_phase = PH_EOL;
          s_eol   = is_lf;
        end else if (c == CH_QUOTE) begin
          s_phase = PH_QUOTE;
        end else begin
          s_app = 1'b1;
        end
      end
      default: begin
        s_phase = PH_EOL;
        s_eol   = is_lf;
      end
    endcase
    if (s_app) begin
      s_emit = 1'b1;
      if (s_base < TEXT_W'(MAX_TEXT)) begin
        s_tl = s_base + TEXT_W'(1);
        s_ev = EV_VALCHAR;
        s_ch = s_ach;
      end else begin
        s_tl   = s_base;
        s_halt = 1'b1;
        s_ev   = EV_OVERFLOW;
      end
    end
  end

  always_comb begin
    e_valid  = 1'b0;
    e_ev     = EV_STOP;
    e_ch     = '0;
    e_len    = '0;
    lvl_next = level;
    case (cmd.op)
      CMD_SIMPLE: begin
        e_valid = s_emit;
        e_ev    = s_ev;
        e_ch    = s_ch;
        e_len   = s_len;
      end
      CMD_STOP: e_valid = 1'b1;
      CMD_PARENT: begin
        e_valid  = 1'b1;
        e_ev     = EV_PARENT;
        lvl_next = level - LEVEL_W'(1);
      end
      CMD_CHILD: begin
        e_valid  = 1'b1;
        e_ev     = EV_CHILD;
        lvl_next = level + LEVEL_W'(1);
      end
      CMD_NEXT: begin
        e_valid = 1'b1;
        e_ev    = EV_NEXT;
      end
      CMD_APPEND: begin
        e_valid = 1'b1;
        if (text_full) begin
          e_ev = EV_OVERFLOW;
        end else begin
          e_ev = EV_KEYCHAR;
          e_ch = c;
        end
      end
      CMD_KEYDONE: begin
        e_valid = 1'b1;
        e_ev    = EV_KEYDONE;
        e_len   = LEN_W'(tl);
      end
      default: e_valid = 1'b0;
    endcase
  end

  assign do_endline = (cmd.op == CMD_SIMPLE && s_eol) ||
                      (cmd.op == CMD_KEYDONE && is_lf);

  always_ff @(posedge clk) begin
    if (rst || cmd.op == CMD_RESTART) begin
      phase       <= PH_INDENT;
      line_indent <= '0;
      level       <= '0;
      tl          <= '0;
      hn          <= '0;
      halted      <= 1'b0;
      for (int i = 0; i < STACK_N; i++) begin
        indent_stack[i] <= '0;
      end
    end else begin
      level <= lvl_next;
      case (cmd.op)
        CMD_SIMPLE: begin
          hn     <= s_hn;
          halted <= s_halt;
          // line end clears the counters and restarts the indent count
          if (s_eol) begin
            line_indent <= '0;
            tl          <= '0;
            phase       <= PH_INDENT;
          end else begin
            phase       <= s_phase;
            line_indent <= s_li;
            tl          <= s_tl;
          end
        end
        CMD_STOP: halted <= 1'b1;
        CMD_APPEND: begin
          phase <= PH_KEY;
          if (text_full) begin
            halted <= 1'b1;
          end else begin
            tl <= tl + TEXT_W'(1);
          end
        end
        CMD_KEYDONE: begin
          if (is_lf) begin
            line_indent <= '0;
            tl          <= '0;
            phase       <= PH_INDENT;
          end else begin
            phase <= is_crlf ? PH_EOL : PH_SEP;
          end
        end
        default: phase <= phase;
      endcase
      if (do_endline) begin
        indent_stack[level] <= line_indent;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_LATCH) begin
      c <= data_byte;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (e_valid) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (e_valid) begin
      out_ev   <= e_ev;
      out_ch   <= e_ch;
      out_len  <= e_len;
      out_dep  <= DEPTH_W'(lvl_next);
      out_last <= cmd.last;
    end
  end

  assign tx.valid      = out_valid;
  assign tx.event_res  = out_ev;
  assign tx.char_out   = out_ch;
  assign tx.str_length = out_len;
  assign tx.depth_now  = out_dep;
  assign tx.last       = out_last;

  assign sta.kind         = kind;
  assign sta.simple_emits = s_emit;
  assign sta.ind_lt       = line_indent < stored;
  assign sta.ind_gt       = line_indent > stored;
  assign sta.level_zero   = (level == '0);
  assign sta.level_max    = (level >= LEVEL_W'(MAX_DEPTH));
  assign sta.dash         = (phase == PH_DASH);
  assign sta.text_full    = text_full;
  assign sta.eol_char     = is_crlf;
  assign sta.colon        = (c == CH_COLON);
  assign sta.halted       = halted;
  assign sta.restart      = action;
  assign sta.out_free     = out_free;

endmodule

>>> hdl/indented_key_value_line_parser_top.sv
// channel | dir | beat contents
// rx      | in  | action, data_byte
// tx      | out | event_res, char_out, str_length, depth_now, last
//
// a byte is latched while the sequencer is idle, then worked from dispatch:
// a byte with at most one event or none ends there, a key byte goes to append
// key or key done, a line's first byte to level, a pop per parent, append first.
// the single output register sets the pace: each event waits for tx to drain.
// rst is synchronous; a restart beat clears the parse state as it is taken.
// rx is accepted whenever the sequencer is idle, even with a beat pending on tx.
module indented_key_value_line_parser_top import iklp_pkg::*; #(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF,
  parameter int MAX_TEXT  = MAX_TEXT_DEF
) (
  input  logic     clk,
  input  logic     rst,
  iklp_in_if.sink  rx,
  iklp_out_if.source tx
);

  cmd_t cmd;
  sta_t sta;
  logic in_ready;

  assign rx.ready = in_ready;

  iklp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_ready (in_ready),
    .sta      (sta),
    .cmd      (cmd)
  );

  iklp_dpath #(
    .MAX_DEPTH (MAX_DEPTH),
    .MAX_TEXT  (MAX_TEXT)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .action    (rx.action),
    .data_byte (rx.data_byte),
    .cmd       (cmd),
    .sta       (sta),
    .tx        (tx)
  );

endmodule
